>>> rtl/grs_pkg.sv
`default_nettype none
package grs_pkg;

    localparam int MAX_GROUP   = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int GSIZE_W     = 5;
    localparam int ADDR_W      = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W       = $clog2(MAX_GROUP + 1);

    localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(2);

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } grs_state_t;

    typedef struct packed {
        logic take;
        logic issue;
    } grs_cmd_t;

    typedef struct packed {
        logic in_emit;
        logic slot_free;
        logic final_beat;
    } grs_stat_t;

endpackage
`default_nettype wire

>>> rtl/grs_if.sv
`default_nettype none
interface grs_in_if import grs_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         list_last;

    modport source (output valid, output value, output list_last, input ready);
    modport sink   (input valid, input value, input list_last, output ready);
endinterface

interface grs_out_if import grs_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         out_list_end;
    logic                         run_end;

    modport source (output valid, output out_value, output out_list_end, output run_end,
                    input ready);
    modport sink   (input valid, input out_value, input out_list_end, input run_end,
                    output ready);
endinterface

interface grs_cfg_if import grs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [GSIZE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/grs_ctrl.sv
`default_nettype none
module grs_ctrl
    import grs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire grs_stat_t stat,
    output grs_cmd_t       cmd
);

    grs_state_t state_reg;
    grs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.take = 1'b1;
                if (stat.in_emit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.issue = stat.slot_free;
                if (stat.slot_free && stat.final_beat)
                begin
                    state_next = ST_FILL;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/grs_datapath.sv
`default_nettype none
module grs_datapath
    import grs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    grs_in_if.sink      in_ch,
    grs_out_if.source   out_ch,
    grs_cfg_if.sink     cfg_ch,
    input  wire grs_cmd_t cmd,
    output grs_stat_t   stat
);

    logic signed [DATA_WIDTH-1:0] mem [MAX_GROUP];

    logic [GSIZE_W-1:0] gsize_reg;
    logic [ADDR_W-1:0]  fill_reg;
    logic [ADDR_W-1:0]  fill_next;
    logic [ADDR_W-1:0]  rd_ptr_reg;
    logic [ADDR_W-1:0]  rd_ptr_next;
    logic [ADDR_W-1:0]  end_ptr_reg;
    logic [ADDR_W-1:0]  end_ptr_next;
    logic               rev_reg;
    logic               rev_next;
    logic               lst_reg;
    logic               lst_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic signed [DATA_WIDTH-1:0] out_value_reg;
    logic                         out_list_end_reg;
    logic                         run_end_reg;

    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] n_sum;
    logic             full;
    logic             accept;
    logic             final_beat;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = cmd.take;
    assign accept       = in_ch.valid && cmd.take;

    always_comb
    begin
        if (gsize_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (int'(gsize_reg) > MAX_GROUP)
        begin
            eff_size = CNT_W'(MAX_GROUP);
        end
        else
        begin
            eff_size = CNT_W'(gsize_reg);
        end
    end

    assign n_sum      = CNT_W'(fill_reg) + CNT_W'(1);
    assign full       = (n_sum >= eff_size);
    assign final_beat = rev_reg ? (rd_ptr_reg == '0) : (rd_ptr_reg == end_ptr_reg);

    assign stat.in_emit    = in_ch.valid && (full || in_ch.list_last);
    assign stat.slot_free  = !out_valid_reg || out_ch.ready;
    assign stat.final_beat = final_beat;

    always_comb
    begin
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        end_ptr_next   = end_ptr_reg;
        rev_next       = rev_reg;
        lst_next       = lst_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        priority if (accept && full)
        begin
            // full group: drain newest first
            fill_next   = '0;
            rev_next    = 1'b1;
            rd_ptr_next = fill_reg;
            lst_next    = in_ch.list_last;
        end
        else if (accept && in_ch.list_last)
        begin
            // partial remainder: drain in arrival order
            fill_next    = '0;
            rev_next     = 1'b0;
            rd_ptr_next  = '0;
            end_ptr_next = fill_reg;
            lst_next     = 1'b1;
        end
        else if (accept)
        begin
            fill_next = ADDR_W'(n_sum);
        end
        else if (cmd.issue)
        begin
            out_valid_next = 1'b1;
            if (rev_reg)
            begin
                rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
            end
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg     <= GSIZE_RESET;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            end_ptr_reg   <= '0;
            rev_reg       <= 1'b0;
            lst_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                gsize_reg <= cfg_ch.data;
            end
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            end_ptr_reg   <= end_ptr_next;
            rev_reg       <= rev_next;
            lst_reg       <= lst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[fill_reg] <= in_ch.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            out_value_reg    <= mem[rd_ptr_reg];
            out_list_end_reg <= lst_reg && final_beat;
            run_end_reg      <= final_beat;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.out_list_end = out_list_end_reg;
    assign out_ch.run_end      = run_end_reg;

    a_issue_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> out_valid_reg)
        else $error("issued beat did not reach the output register");

    a_issue_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!out_valid_reg || out_ch.ready))
        else $error("beat issued over a pending result");

    a_emit_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (full || in_ch.list_last)) |=> (fill_reg == '0))
        else $error("fill count not cleared after a group was closed");

    a_no_take_while_issue: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.issue && cmd.take))
        else $error("input taken while draining");

endmodule
`default_nettype wire

>>> rtl/group_reverse_stream_core.sv
`default_nettype none
// Group reversing stream: list elements enter one per beat on in_ch, each with
// list_last on the final element. Elements are buffered in a 16-entry store
// until a group of group_size (written on cfg_ch, reset value 2, 0 acts as 1,
// values above 16 act as 16) is complete; that group then leaves on out_ch
// newest first. A list that ends on a partial group leaves in arrival order.
// An element that closes no group is only stored; one that closes a group of
// r elements is followed by r reads from the store, one result per cycle
// except while out_ch holds ready low. The input is not taken while a group
// drains; the last result of a group sits in the output register while the
// next element is accepted. run_end marks the last result of each group and
// out_list_end the last result of the list.
module group_reverse_stream_core
    import grs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    grs_in_if.sink    in_ch,
    grs_out_if.source out_ch,
    grs_cfg_if.sink   cfg_ch
);

    grs_cmd_t  cmd;
    grs_stat_t stat;

    grs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    grs_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
`default_nettype wire
